### rtl/core/cmpa_pkg.sv
// ============================================================================
// cmpa_pkg - shared types and constants for the mode string parser
// Character codes, permission masks, status codes and the parser state record.
// ============================================================================
`default_nettype none

package cmpa_pkg;

   // ASCII codes recognised by the parser
   localparam logic [7:0] CH_0     = 8'h30;
   localparam logic [7:0] CH_7     = 8'h37;
   localparam logic [7:0] CH_9     = 8'h39;
   localparam logic [7:0] CH_U     = 8'h75;
   localparam logic [7:0] CH_G     = 8'h67;
   localparam logic [7:0] CH_O     = 8'h6f;
   localparam logic [7:0] CH_A     = 8'h61;
   localparam logic [7:0] CH_PLUS  = 8'h2b;
   localparam logic [7:0] CH_MINUS = 8'h2d;
   localparam logic [7:0] CH_EQUAL = 8'h3d;
   localparam logic [7:0] CH_COMMA = 8'h2c;
   localparam logic [7:0] CH_R     = 8'h72;
   localparam logic [7:0] CH_W     = 8'h77;
   localparam logic [7:0] CH_X     = 8'h78;
   localparam logic [7:0] CH_T     = 8'h74;
   localparam logic [7:0] CH_S     = 8'h73;

   // Class and permission masks (octal)
   localparam logic [11:0] CLS_U    = 12'o4700;
   localparam logic [11:0] CLS_G    = 12'o2070;
   localparam logic [11:0] CLS_O    = 12'o0007;
   localparam logic [11:0] CLS_A    = 12'o6777;
   localparam logic [11:0] PRM_R    = 12'o0444;
   localparam logic [11:0] PRM_W    = 12'o0222;
   localparam logic [11:0] PRM_X    = 12'o0111;
   localparam logic [11:0] PRM_T    = 12'o1000;
   localparam logic [11:0] PRM_S    = 12'o6000;
   localparam logic [11:0] MASK_ALL = 12'o7777;

   // Stored error codes
   localparam logic [2:0] ERR_NONE       = 3'd0;
   localparam logic [2:0] ERR_BAD_CLASS  = 3'd2;
   localparam logic [2:0] ERR_INCOMPLETE = 3'd3;
   localparam logic [2:0] ERR_BAD_PERM   = 3'd4;
   localparam logic [2:0] ERR_SETID      = 3'd5;
   localparam logic [2:0] ERR_NO_CLASS   = 3'd6;
   localparam logic [2:0] ERR_BAD_DIGIT  = 3'd7;

   // Result status codes
   localparam logic [3:0] ST_OK       = 4'd0;
   localparam logic [3:0] ST_DONE     = 4'd1;
   localparam logic [3:0] ST_APPLIED  = 4'd8;
   localparam logic [3:0] ST_NO_MASKS = 4'd9;

   typedef enum logic [1:0] {
      PH_CLASS  = 2'd0,
      PH_ACTION = 2'd1,
      PH_PERM   = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      ACT_ADD = 2'd0,
      ACT_SUB = 2'd1,
      ACT_SET = 2'd2
   } action_type;

   typedef struct packed {
      logic        func;
      logic [7:0]  mode_char;
      logic        last_char;
      logic [11:0] old_perms;
   } item_type;

   typedef struct packed {
      logic [3:0]  status;
      logic [11:0] new_perms;
      logic        changed;
      logic [11:0] clear_mask;
      logic [11:0] flip_mask;
   } result_type;

   typedef struct packed {
      logic        in_string;
      logic        numeric_mode;
      phase_type   parse_phase;
      logic [2:0]  error_code;
      logic [11:0] class_bits;
      logic [11:0] perm_bits;
      action_type  action_kind;
      logic [11:0] clear_acc;
      logic [11:0] flip_acc;
      logic        masks_valid;
   } state_type;

   localparam state_type STATE_RESET = '{
      in_string:    1'b0,
      numeric_mode: 1'b0,
      parse_phase:  PH_CLASS,
      error_code:   ERR_NONE,
      class_bits:   12'd0,
      perm_bits:    12'd0,
      action_kind:  ACT_ADD,
      clear_acc:    12'd0,
      flip_acc:     12'd0,
      masks_valid:  1'b0
   };

endpackage : cmpa_pkg

`default_nettype wire

### rtl/core/cmpa_step.sv
// ============================================================================
// cmpa_step - one parser or apply step
// Combinational next state and result for a single transaction.
// ============================================================================
`default_nettype none

module cmpa_step (
   input  cmpa_pkg::state_type  state_cur,
   input  cmpa_pkg::item_type   item,
   output cmpa_pkg::state_type  state_nxt,
   output cmpa_pkg::result_type result
);
   import cmpa_pkg::*;

   always_comb begin
      state_type   s;
      logic [2:0]  err;
      logic [7:0]  c;
      logic        comma_close;
      logic        need_close;
      logic [11:0] p;
      logic [11:0] new_p;

      s           = state_cur;
      c           = item.mode_char;
      err         = ERR_NONE;
      comma_close = 1'b0;
      need_close  = 1'b0;
      p           = 12'd0;
      new_p       = 12'd0;

      result.status     = ST_OK;
      result.new_perms  = 12'd0;
      result.changed    = 1'b0;

      if (item.func) begin
         if (s.masks_valid) begin
            new_p            = (item.old_perms & ~s.clear_acc) ^ s.flip_acc;
            result.new_perms = new_p;
            result.changed   = (new_p != item.old_perms);
            result.status    = ST_APPLIED;
         end else begin
            result.new_perms = item.old_perms;
            result.status    = ST_NO_MASKS;
         end
      end else begin
         // first character opens a new string
         if (!s.in_string) begin
            s.in_string    = 1'b1;
            s.numeric_mode = (c inside {[CH_0:CH_9]});
            s.parse_phase  = PH_CLASS;
            s.error_code   = ERR_NONE;
            s.class_bits   = 12'd0;
            s.perm_bits    = 12'd0;
            s.action_kind  = ACT_ADD;
            s.clear_acc    = s.numeric_mode ? MASK_ALL : 12'd0;
            s.flip_acc     = 12'd0;
            s.masks_valid  = 1'b0;
         end

         err = s.error_code;

         if (s.error_code != ERR_NONE) begin
            // sticky: ignore the rest of the string
         end else if (s.numeric_mode) begin
            if (c inside {[CH_0:CH_7]}) begin
               s.flip_acc = {s.flip_acc[8:0], c[2:0]};
            end else begin
               err = ERR_BAD_DIGIT;
            end
         end else if (s.parse_phase == PH_CLASS) begin
            case (c)
               CH_U:     s.class_bits = s.class_bits | CLS_U;
               CH_G:     s.class_bits = s.class_bits | CLS_G;
               CH_O:     s.class_bits = s.class_bits | CLS_O;
               CH_A:     s.class_bits = s.class_bits | CLS_A;
               CH_PLUS: begin
                  s.action_kind = ACT_ADD;
                  s.parse_phase = PH_ACTION;
               end
               CH_MINUS: begin
                  s.action_kind = ACT_SUB;
                  s.parse_phase = PH_ACTION;
               end
               CH_EQUAL: begin
                  s.action_kind = ACT_SET;
                  s.parse_phase = PH_ACTION;
               end
               CH_COMMA: err = ERR_INCOMPLETE;
               default:  err = ERR_BAD_CLASS;
            endcase
         end else if ((s.parse_phase == PH_PERM) && (c == CH_COMMA)) begin
            comma_close = 1'b1;
            need_close  = 1'b1;
         end else if (c == CH_COMMA) begin
            err = ERR_INCOMPLETE;
         end else begin
            // permission letter, straight after the action or later
            s.parse_phase = PH_PERM;
            case (c)
               CH_R: s.perm_bits = s.perm_bits | PRM_R;
               CH_W: s.perm_bits = s.perm_bits | PRM_W;
               CH_X: s.perm_bits = s.perm_bits | PRM_X;
               CH_T: begin
                  s.perm_bits  = s.perm_bits | PRM_T;
                  s.class_bits = s.class_bits | PRM_T;
               end
               CH_S: begin
                  if (((s.class_bits & CLS_A) != CLS_U) &&
                      ((s.class_bits & CLS_A) != CLS_G)) begin
                     err = ERR_SETID;
                  end else begin
                     s.perm_bits = s.perm_bits | PRM_S;
                  end
               end
               default: err = ERR_BAD_PERM;
            endcase
         end

         // end of string closes an open clause, or flags one that has no permission yet
         if ((err == ERR_NONE) && item.last_char && !s.numeric_mode && !comma_close) begin
            if (s.parse_phase == PH_PERM) begin
               need_close = 1'b1;
            end else begin
               err = ERR_INCOMPLETE;
            end
         end

         if (need_close) begin
            if (((s.class_bits & CLS_A) == 12'd0) &&
                ((s.perm_bits & ~s.class_bits) != 12'd0)) begin
               err = ERR_NO_CLASS;
            end else begin
               p = s.perm_bits & s.class_bits;
               case (s.action_kind)
                  ACT_ADD: begin
                     s.clear_acc = s.clear_acc | p;
                     s.flip_acc  = s.flip_acc | p;
                  end
                  ACT_SUB: begin
                     s.clear_acc = s.clear_acc | p;
                     s.flip_acc  = s.flip_acc & ~p;
                  end
                  default: begin
                     s.clear_acc = s.clear_acc | s.class_bits;
                     s.flip_acc  = s.flip_acc | p;
                  end
               endcase
               s.class_bits  = 12'd0;
               s.perm_bits   = 12'd0;
               s.parse_phase = PH_CLASS;
            end
         end

         if ((err == ERR_NONE) && item.last_char) begin
            s.masks_valid = 1'b1;
            result.status = ST_DONE;
         end
         if (err != ERR_NONE) begin
            result.status = {1'b0, err};
         end
         s.error_code = err;
         if (item.last_char) begin
            s.in_string = 1'b0;
         end
      end

      result.clear_mask = s.clear_acc;
      result.flip_mask  = s.flip_acc;
      state_nxt         = s;
   end

endmodule : cmpa_step

`default_nettype wire

### rtl/core/chmod_mode_parse_apply.sv
// ============================================================================
// chmod_mode_parse_apply - streaming chmod mode string parser with apply step
// Builds clear and flip masks from a mode string and applies them to a
// 12-bit permission word.
// ============================================================================
// Usage:
//  - req_* carries one transaction: either one mode string character
//    (req_func low, req_last_char marks the end of the string) or an apply
//    request (req_func high) on req_old_perms.
//  - rsp_* returns exactly one result per transaction, in order: a status
//    code, the applied permissions, the changed flag and both masks.
//  - A transaction is taken when valid is high and stall is low.
//  - The transaction sits in the input register, and the parse step's
//    result is written into the result register once that is free.
//  - Throughput: one transaction per cycle while rsp_stall is low; the parse
//    step is one combinational pass from the input to the result register.
//  - A stalled result holds; the input register still takes one more
//    transaction, then req_stall rises until the result is taken.
//  - Synchronous reset empties both registers and returns the parser to
//    its idle state with no masks held.
// ============================================================================
`default_nettype none

module chmod_mode_parse_apply (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_func,
   input  wire logic [7:0]  req_mode_char,
   input  wire logic        req_last_char,
   input  wire logic [11:0] req_old_perms,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [3:0]       rsp_status,
   output logic [11:0]      rsp_new_perms,
   output logic             rsp_changed,
   output logic [11:0]      rsp_clear_mask,
   output logic [11:0]      rsp_flip_mask
);
   import cmpa_pkg::*;

   // input register
   logic       in_valid_ff;
   item_type   in_item_ff;

   // parser state
   state_type  state_ff;
   state_type  state_in;

   // result register
   logic       out_valid_ff;
   result_type out_ff;
   result_type out_in;

   logic       out_free;
   logic       fire;
   logic       req_take;

   // result register can load when empty or being drained this cycle
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign fire      = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   cmpa_step u_step (
      .state_cur (state_ff),
      .item      (in_item_ff),
      .state_nxt (state_in),
      .result    (out_in)
   );

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= STATE_RESET;
      end else begin
         if (!req_stall) begin
            in_valid_ff <= req_valid;
         end
         if (fire) begin
            out_valid_ff <= 1'b1;
            state_ff     <= state_in;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff.func      <= req_func;
         in_item_ff.mode_char <= req_mode_char;
         in_item_ff.last_char <= req_last_char;
         in_item_ff.old_perms <= req_old_perms;
      end
      if (fire) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_status     = out_ff.status;
   assign rsp_new_perms  = out_ff.new_perms;
   assign rsp_changed    = out_ff.changed;
   assign rsp_clear_mask = out_ff.clear_mask;
   assign rsp_flip_mask  = out_ff.flip_mask;

endmodule : chmod_mode_parse_apply

`default_nettype wire
